// File: rtl/core/jpm_pkg.sv
// jpm_pkg: shared types and constants for the jet pseudocolor map
// used by jpm_log2, jpm_div, jpm_jet and jet_pseudocolor_map; no dependencies
`default_nettype none

package jpm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SAMPLE_W   = 32;
    localparam int LOG_W      = 21;
    localparam int Q_W        = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_MODE   = 2'd2;

    // q1.16 constants (1.0 = 65536), the U_ ones signed
    localparam logic [16:0]        Q16_ONE    = 17'd65536;
    localparam logic [16:0]        ROUND_HALF = 17'd32768;
    localparam logic signed [18:0] U_HALF     = 19'sd32768;
    localparam logic signed [18:0] U_QUARTER  = 19'sd16384;
    localparam logic signed [18:0] U_THREEQ   = 19'sd49152;

    // floor(x / 10000) = (x * RAISE_MUL) >> RAISE_SHIFT for x < 2^31
    localparam logic [31:0] RAISE_MUL   = 32'd3518437209;
    localparam int          RAISE_SHIFT = 45;

    typedef enum logic [1:0] {
        RK_DIV,
        RK_ZERO,
        RK_ONE
    } ratio_kind_t;

endpackage

`default_nettype wire

// File: rtl/core/jpm_log2.sv
// jpm_log2: three-stage fixed-point log2 (leading one, table lookup, interpolation)
// result is position * 65536 + fraction; uses jpm_pkg
`default_nettype none

module jpm_log2 (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [31:0]               x_in,
    output logic      [jpm_pkg::LOG_W-1:0] y_out
);

    localparam int LW = jpm_pkg::LOG_W;

    function automatic logic [16:0] log_tab(input logic [4:0] idx);
        case (idx)
            5'd0:    return 17'd0;
            5'd1:    return 17'd5732;
            5'd2:    return 17'd11136;
            5'd3:    return 17'd16248;
            5'd4:    return 17'd21098;
            5'd5:    return 17'd25711;
            5'd6:    return 17'd30109;
            5'd7:    return 17'd34312;
            5'd8:    return 17'd38336;
            5'd9:    return 17'd42196;
            5'd10:   return 17'd45904;
            5'd11:   return 17'd49472;
            5'd12:   return 17'd52911;
            5'd13:   return 17'd56229;
            5'd14:   return 17'd59434;
            5'd15:   return 17'd62534;
            5'd16:   return 17'd65536;
            default: return 17'd0;
        endcase
    endfunction

    logic [4:0]    pos;
    logic [31:0]   norm;
    logic [4:0]    p1_reg;
    logic [3:0]    i1_reg;
    logic [11:0]   r1_reg;
    logic [16:0]   lo;
    logic [16:0]   hi;
    logic [12:0]   diff;
    logic [24:0]   prod;
    logic [4:0]    p2_reg;
    logic [15:0]   lo2_reg;
    logic [24:0]   prod2_reg;
    logic [LW-1:0] y_reg;

    // leading one and normalize
    always_comb begin
        pos = '0;
        for (int b = 0; b < 32; b++) begin
            if (x_in[b]) begin
                pos = 5'(b);
            end
        end
        norm = x_in << (5'd31 - pos);
    end

    // table segment and interpolation product
    always_comb begin
        lo   = log_tab({1'b0, i1_reg});
        hi   = log_tab({1'b0, i1_reg} + 5'd1);
        diff = 13'(hi - lo);
        prod = 25'(diff) * 25'(r1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= pos;
            i1_reg    <= norm[30:27];
            r1_reg    <= norm[26:15];
            p2_reg    <= p1_reg;
            lo2_reg   <= lo[15:0];
            prod2_reg <= prod;
            y_reg     <= {p2_reg, 16'b0} + LW'(lo2_reg) + LW'(prod2_reg[24:12]);
        end
    end

    assign y_out = y_reg;

endmodule

`default_nettype wire

// File: rtl/core/jpm_div.sv
// jpm_div: pipelined restoring divider, one quotient bit per stage
// computes (n << 16) / d for n < d and carries the ratio kind alongside; uses jpm_pkg
`default_nettype none

module jpm_div (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [31:0]             n_in,
    input  wire logic [31:0]             d_in,
    input  wire jpm_pkg::ratio_kind_t    kind_in,
    output logic [jpm_pkg::Q_W-1:0]      q_out,
    output jpm_pkg::ratio_kind_t         kind_out
);

    localparam int STEPS = jpm_pkg::Q_W;

    logic [31:0]          rem_reg  [STEPS-1];
    logic [31:0]          dvs_reg  [STEPS-1];
    logic [STEPS-1:0]     q_reg    [STEPS];
    jpm_pkg::ratio_kind_t kind_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [31:0]          rem_in;
        logic [31:0]          dvs_in;
        logic [STEPS-1:0]     q_in;
        jpm_pkg::ratio_kind_t kind_k;
        logic [33:0]          trial;

        if (k == 0) begin : g_first
            assign rem_in = n_in;
            assign dvs_in = d_in;
            assign q_in   = '0;
            assign kind_k = kind_in;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign kind_k = kind_reg[k-1];
        end

        assign trial = {1'b0, rem_in, 1'b0} - {2'b0, dvs_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k]    <= {q_in[STEPS-2:0], ~trial[33]};
                kind_reg[k] <= kind_k;
            end
        end

        if (k < STEPS - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!trial[33]) begin
                        rem_reg[k] <= trial[31:0];
                    end else begin
                        rem_reg[k] <= {rem_in[30:0], 1'b0};
                    end
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    end

    assign q_out    = q_reg[STEPS-1];
    assign kind_out = kind_reg[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/core/jpm_jet.sv
// jpm_jet: jet trapezoid for the three channels and scaling to color levels
// two register stages; uses jpm_pkg
`default_nettype none

module jpm_jet #(
    parameter int COLOR_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [16:0]           v_in,
    output logic      [COLOR_BITS-1:0] red_out,
    output logic      [COLOR_BITS-1:0] green_out,
    output logic      [COLOR_BITS-1:0] blue_out
);

    localparam int                    LW   = COLOR_BITS + 18;
    localparam logic [COLOR_BITS-1:0] FULL = '1;

    function automatic logic [16:0] jet_base(input logic signed [18:0] u);
        logic signed [18:0] t;
        t = '0;
        if (u <= -jpm_pkg::U_THREEQ) begin
            return 17'd0;
        end else if (u <= -jpm_pkg::U_QUARTER) begin
            t = u + jpm_pkg::U_THREEQ;
            return {t[15:0], 1'b0};
        end else if (u <= jpm_pkg::U_QUARTER) begin
            return jpm_pkg::Q16_ONE;
        end else if (u <= jpm_pkg::U_THREEQ) begin
            t = jpm_pkg::U_THREEQ - u;
            return {t[15:0], 1'b0};
        end
        return 17'd0;
    endfunction

    function automatic logic [COLOR_BITS-1:0] to_level(input logic [16:0] b);
        logic [LW-1:0] acc;
        acc = LW'(b) * LW'(FULL) + LW'(jpm_pkg::ROUND_HALF);
        return acc[COLOR_BITS+15:16];
    endfunction

    logic signed [18:0]    vs;
    logic [16:0]           br_reg;
    logic [16:0]           bg_reg;
    logic [16:0]           bb_reg;
    logic [COLOR_BITS-1:0] red_reg;
    logic [COLOR_BITS-1:0] green_reg;
    logic [COLOR_BITS-1:0] blue_reg;

    assign vs = signed'({2'b0, v_in});

    always_ff @(posedge aclk) begin
        if (en) begin
            br_reg    <= jet_base(vs - jpm_pkg::U_HALF);
            bg_reg    <= jet_base(vs);
            bb_reg    <= jet_base(vs + jpm_pkg::U_HALF);
            red_reg   <= to_level(br_reg);
            green_reg <= to_level(bg_reg);
            blue_reg  <= to_level(bb_reg);
        end
    end

    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

`default_nettype wire

// File: rtl/core/jet_pseudocolor_map.sv
// jet_pseudocolor_map: top level, signed q16.16 sample to jet color triple
// uses jpm_pkg, jpm_log2, jpm_div and jpm_jet
//
// usage
//   s_tdata carries one signed q16.16 sample per transfer; m_tdata returns
//   red, green and blue levels (COLOR_BITS each, all ones means full scale).
//   range_low, range_high and log_mode are set through the cfg_wr_* port
//   (index 0, 1, 2; other indexes are ignored) while no transfer is in flight.
//   pipeline: 26 register stages, namely input, two linear-normalize stages,
//   the log clamp, three log2 stages, divider setup, 16 divider stages (one
//   quotient bit each) and two color stages.
//   throughput: one transfer per cycle while m_tready is high.
//   stall: when m_tvalid is high and m_tready low, every stage holds and
//   s_tready drops; nothing is lost or repeated.
//   reset: the pipeline empties and the registers return to low 0,
//   high 1.0 and linear mode.
`default_nettype none

module jet_pseudocolor_map #(
    parameter  int COLOR_BITS = 8,
    localparam int TDATA_W    = ((3 * COLOR_BITS + 7) / 8) * 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [31:0]                      s_tdata,      // sample
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [TDATA_W-1:0]               m_tdata,      // red, green, blue level
    input  wire logic                             cfg_wr_en,
    input  wire logic [jpm_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire logic [jpm_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    localparam int DIV_STEPS   = jpm_pkg::Q_W;
    localparam int PIPE_STAGES = 8 + DIV_STEPS + 2;
    localparam int SIDE_STAGES = 6;
    localparam int LAST        = PIPE_STAGES - 1;
    localparam int LW          = jpm_pkg::LOG_W;

    typedef struct packed {
        logic signed [32:0] lin_num;
        logic signed [32:0] lin_den;
        logic               zero;
        logic               logm;
    } side_t;

    logic signed [31:0]   range_low_reg;
    logic signed [31:0]   range_high_reg;
    logic                 log_mode_reg;
    logic [62:0]          raise_prod_reg;
    logic signed [32:0]   raised_reg;

    logic                 adv;
    logic [LAST:0]        vld_reg;

    logic [31:0]          x0_reg;
    logic [31:0]          x1_reg;
    logic [31:0]          x2_reg;
    logic [31:0]          xc3_reg;
    logic [31:0]          xc_next;
    side_t                side_next;
    side_t                side_reg [SIDE_STAGES];

    logic [LW-1:0]        lx;
    logic [LW-1:0]        ll;
    logic [LW-1:0]        lh;

    logic signed [33:0]   num;
    logic signed [33:0]   den;
    jpm_pkg::ratio_kind_t kind_next;
    logic [31:0]          n7_reg;
    logic [31:0]          d7_reg;
    jpm_pkg::ratio_kind_t kind7_reg;

    logic [DIV_STEPS-1:0] div_q;
    jpm_pkg::ratio_kind_t div_kind;
    logic [16:0]          v;

    logic [COLOR_BITS-1:0] red_level;
    logic [COLOR_BITS-1:0] green_level;
    logic [COLOR_BITS-1:0] blue_level;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= '0;
            range_high_reg <= signed'(32'(jpm_pkg::Q16_ONE));
            log_mode_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                jpm_pkg::REG_RANGE_LOW:  range_low_reg  <= signed'(cfg_wr_data);
                jpm_pkg::REG_RANGE_HIGH: range_high_reg <= signed'(cfg_wr_data);
                jpm_pkg::REG_LOG_MODE:   log_mode_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // low * 1.0001, registered through raise_prod_reg and then raised_reg
    always_ff @(posedge aclk) begin
        raise_prod_reg <= {32'b0, range_low_reg[30:0]} * {31'b0, jpm_pkg::RAISE_MUL};
        raised_reg     <= {range_low_reg[31], range_low_reg}
                        + signed'({15'b0, raise_prod_reg[62:jpm_pkg::RAISE_SHIFT]});
    end

    // bound logs of the range registers, registered inside jpm_log2
    jpm_log2 u_log_low (
        .aclk  (aclk),
        .en    (1'b1),
        .x_in  (range_low_reg),
        .y_out (ll)
    );

    jpm_log2 u_log_high (
        .aclk  (aclk),
        .en    (1'b1),
        .x_in  (range_high_reg),
        .y_out (lh)
    );

    // pipeline control
    assign adv      = ~vld_reg[LAST] | m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAST-1:0], s_tvalid};
        end
    end

    // linear terms and special flags
    always_comb begin
        side_next.lin_num = {x0_reg[31], x0_reg} - {range_low_reg[31], range_low_reg};
        side_next.lin_den = {range_high_reg[31], range_high_reg}
                          - {range_low_reg[31], range_low_reg};
        side_next.zero    = (range_high_reg <= range_low_reg)
                          || (log_mode_reg && (range_low_reg <= 32'sd0));
        side_next.logm    = log_mode_reg;
    end

    // log clamp: samples at or below low become low * 1.0001, then the result is capped at high
    always_comb begin
        logic signed [32:0] x2_ext;
        logic signed [32:0] xc_ext;
        x2_ext = signed'({x2_reg[31], x2_reg});
        xc_ext = x2_ext;
        if (x2_ext <= signed'({range_low_reg[31], range_low_reg})) begin
            xc_ext = raised_reg;
        end
        if (xc_ext > signed'({range_high_reg[31], range_high_reg})) begin
            xc_ext = signed'({range_high_reg[31], range_high_reg});
        end
        xc_next = xc_ext[31:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg      <= s_tdata;
            x1_reg      <= x0_reg;
            x2_reg      <= x1_reg;
            xc3_reg     <= xc_next;
            side_reg[0] <= side_next;
            for (int k = 1; k < SIDE_STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    jpm_log2 u_log_sample (
        .aclk  (aclk),
        .en    (adv),
        .x_in  (xc3_reg),
        .y_out (lx)
    );

    // divider operands and ratio kind
    always_comb begin
        if (side_reg[SIDE_STAGES-1].logm) begin
            num = signed'({13'b0, lx} - {13'b0, ll});
            den = signed'({13'b0, lh} - {13'b0, ll});
        end else begin
            num = {side_reg[SIDE_STAGES-1].lin_num[32], side_reg[SIDE_STAGES-1].lin_num};
            den = {side_reg[SIDE_STAGES-1].lin_den[32], side_reg[SIDE_STAGES-1].lin_den};
        end
        if (side_reg[SIDE_STAGES-1].zero || (den <= 34'sd0) || (num <= 34'sd0)) begin
            kind_next = jpm_pkg::RK_ZERO;
        end else if (num >= den) begin
            kind_next = jpm_pkg::RK_ONE;
        end else begin
            kind_next = jpm_pkg::RK_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n7_reg    <= num[31:0];
            d7_reg    <= den[31:0];
            kind7_reg <= kind_next;
        end
    end

    jpm_div u_div (
        .aclk     (aclk),
        .en       (adv),
        .n_in     (n7_reg),
        .d_in     (d7_reg),
        .kind_in  (kind7_reg),
        .q_out    (div_q),
        .kind_out (div_kind)
    );

    always_comb begin
        case (div_kind)
            jpm_pkg::RK_ONE: v = jpm_pkg::Q16_ONE;
            jpm_pkg::RK_DIV: v = {1'b0, div_q};
            default:         v = '0;
        endcase
    end

    jpm_jet #(
        .COLOR_BITS (COLOR_BITS)
    ) u_jet (
        .aclk      (aclk),
        .en        (adv),
        .v_in      (v),
        .red_out   (red_level),
        .green_out (green_level),
        .blue_out  (blue_level)
    );

    assign m_tdata = TDATA_W'({blue_level, green_level, red_level});

    // input side only blocks behind a stalled result
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a stalled result");

    // flagged items bypass the divider as zero
    a_zero_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_reg[SIDE_STAGES] && side_reg[SIDE_STAGES-1].zero)
        |=> (kind7_reg == jpm_pkg::RK_ZERO))
        else $error("flagged item did not become a zero ratio");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: tb/jpm_checker.sv
`timescale 1ns / 100ps
// jpm_checker: watches the register port and both streams of jet_pseudocolor_map,
// predicts each color triple and compares it; uses jpm_pkg
module jpm_checker #(
    parameter int COLOR_BITS = 8,
    parameter int TDATA_W    = ((3 * COLOR_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [31:0]                     s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [TDATA_W-1:0]              m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [jpm_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [jpm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output int                              fail_count,
    output int                              due_count
);

    localparam longint Q_ONE     = 65536;
    localparam longint Q_HALF    = 32768;
    localparam longint Q_QUARTER = 16384;
    localparam longint Q_THREEQ  = 49152;

    typedef struct packed {
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red;
    } jet_rgb_t;

    // log2 fraction at sixteenths of an octave
    longint   log_frac_tab [0:16] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
                                      38336, 42196, 45904, 49472, 52911, 56229, 59434,
                                      62534, 65536};
    longint   lo_bound  = 0;
    longint   hi_bound  = Q_ONE;
    bit       log_scale = 1'b0;
    jet_rgb_t rgb_due [$];
    int       mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("tb: %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    function automatic longint log2_q16(logic [31:0] x);
        int          lead;
        logic [31:0] m;
        logic [3:0]  seg;
        logic [11:0] frac;
        longint      lo_t;
        longint      hi_t;
        lead = 31;
        while (lead > 0 && !x[lead])
            lead--;
        m    = x << (31 - lead);
        seg  = m[30:27];
        frac = m[26:15];
        lo_t = log_frac_tab[int'(seg)];
        hi_t = log_frac_tab[int'(seg) + 1];
        return longint'(lead) * Q_ONE + lo_t + (((hi_t - lo_t) * longint'(frac)) >>> 12);
    endfunction

    function automatic longint norm_ratio(longint num, longint den);
        if (den <= 0 || num <= 0)
            return 0;
        if (num >= den)
            return Q_ONE;
        return (num * Q_ONE) / den;
    endfunction

    function automatic longint jet_ramp(longint u);
        if (u <= -Q_THREEQ)
            return 0;
        if (u <= -Q_QUARTER)
            return (u + Q_THREEQ) * 2;
        if (u <= Q_QUARTER)
            return Q_ONE;
        if (u <= Q_THREEQ)
            return (Q_THREEQ - u) * 2;
        return 0;
    endfunction

    function automatic logic [COLOR_BITS-1:0] channel_level(longint b);
        longint full;
        longint lv;
        full = (longint'(1) << COLOR_BITS) - 1;
        lv   = (b * full + Q_HALF) >>> 16;
        return lv[COLOR_BITS-1:0];
    endfunction

    function automatic jet_rgb_t jet_colors(logic [31:0] smp);
        longint   x;
        longint   v;
        longint   raised;
        longint   lx;
        longint   ll;
        longint   lh;
        jet_rgb_t c;
        x = longint'($signed(smp));
        v = 0;
        if (hi_bound > lo_bound) begin
            if (!log_scale) begin
                v = norm_ratio(x - lo_bound, hi_bound - lo_bound);
            end else if (lo_bound > 0) begin
                raised = lo_bound + lo_bound / 10000;
                if (x <= lo_bound)
                    x = raised;
                if (x > hi_bound)
                    x = hi_bound;
                lx = log2_q16(x[31:0]);
                ll = log2_q16(lo_bound[31:0]);
                lh = log2_q16(hi_bound[31:0]);
                v  = norm_ratio(lx - ll, lh - ll);
            end
        end
        c.red   = channel_level(jet_ramp(v - Q_HALF));
        c.green = channel_level(jet_ramp(v));
        c.blue  = channel_level(jet_ramp(v + Q_HALF));
        return c;
    endfunction

    always @(posedge aclk) begin : watch
        jet_rgb_t got;
        jet_rgb_t want;
        if (!aresetn) begin
            lo_bound  = 0;
            hi_bound  = Q_ONE;
            log_scale = 1'b0;
            rgb_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                rgb_due.push_back(jet_colors(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[3*COLOR_BITS-1:0];
                if (rgb_due.size() == 0) begin
                    report_mismatch("result with nothing due", longint'(m_tdata), -1);
                end else begin
                    want = rgb_due.pop_front();
                    if (got.red !== want.red)
                        report_mismatch("red level", got.red, want.red);
                    if (got.green !== want.green)
                        report_mismatch("green level", got.green, want.green);
                    if (got.blue !== want.blue)
                        report_mismatch("blue level", got.blue, want.blue);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    jpm_pkg::REG_RANGE_LOW:  lo_bound = longint'($signed(cfg_wr_data));
                    jpm_pkg::REG_RANGE_HIGH: hi_bound = longint'($signed(cfg_wr_data));
                    jpm_pkg::REG_LOG_MODE:   log_scale = cfg_wr_data[0];
                    default: ;
                endcase
            end
        end
        due_count <= rgb_due.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: clock, reset, sample and register stimulus and the verdict for jet_pseudocolor_map
// instantiates the block and jpm_checker; uses jpm_pkg
module tb_top;

    localparam int     CB          = 8;
    localparam int     TDATA_W     = ((3 * CB + 7) / 8) * 8;
    localparam int     LONG_HOLD   = 120;
    localparam int     RAND_PHASES = 12;
    localparam int     PHASE_ITEMS = 45;
    localparam longint S_MIN       = -64'sd2147483648;
    localparam longint S_MAX       = 64'sd2147483647;
    localparam logic [jpm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                            aclk         = 1'b0;
    logic                            aresetn      = 1'b0;
    logic                            s_tvalid     = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata      = '0;
    logic                            m_tvalid;
    logic                            m_tready     = 1'b0;
    logic [TDATA_W-1:0]              m_tdata;
    logic                            cfg_wr_en    = 1'b0;
    logic [jpm_pkg::CFG_IDX_W-1:0]   cfg_wr_index = '0;
    logic [jpm_pkg::CFG_DATA_W-1:0]  cfg_wr_data  = '0;
    int                              fail_count;
    int                              due_count;
    bit                              calm         = 1'b0;
    bit                              hold_long    = 1'b0;

    jet_pseudocolor_map #(.COLOR_BITS(CB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    jpm_checker #(.COLOR_BITS(CB), .TDATA_W(TDATA_W)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .due_count(due_count)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_long = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [31:0] smp);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0)
            @(posedge aclk);
    endtask

    task automatic set_regs(input longint lo, input longint hi, input bit lg);
        logic [31:0] junk;
        junk = $urandom;
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= jpm_pkg::REG_RANGE_LOW;
        cfg_wr_data  <= lo[31:0];
        @(posedge aclk);
        cfg_wr_index <= jpm_pkg::REG_RANGE_HIGH;
        cfg_wr_data  <= hi[31:0];
        @(posedge aclk);
        cfg_wr_index <= jpm_pkg::REG_LOG_MODE;
        cfg_wr_data  <= {junk[31:1], lg};
        @(posedge aclk);
        cfg_wr_index <= REG_SPARE;
        cfg_wr_data  <= $urandom;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample(longint lo, longint hi);
        longint a;
        longint b;
        longint span;
        longint x;
        if (lo < hi) begin
            a = lo;
            b = hi;
        end else begin
            a = hi;
            b = lo;
        end
        case ($urandom_range(0, 9))
            0, 1: x = longint'($signed($urandom));
            2:    x = lo + longint'($urandom_range(0, 2)) - 1;
            3:    x = hi + longint'($urandom_range(0, 2)) - 1;
            default: begin
                span = b - a;
                a = a - span / 4 - 4;
                b = b + span / 4 + 4;
                x = a + longint'({$urandom, $urandom} % (b - a + 1));
            end
        endcase
        if (x > S_MAX)
            x = S_MAX;
        if (x < S_MIN)
            x = S_MIN;
        return x[31:0];
    endfunction

    initial begin
        longint lo;
        longint hi;
        bit     lg;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: linear over 0..1.0, every ramp segment
        send_sample(32'h0000_0000);
        send_sample(32'h0000_2000);
        send_sample(32'h0000_4000);
        send_sample(32'h0000_6000);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_A000);
        send_sample(32'h0000_C000);
        send_sample(32'h0000_E000);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        drain();

        // empty range
        set_regs(65536, 65536, 1'b0);
        send_sample(32'h0001_0000);
        send_sample(32'h7FFF_FFFF);
        drain();

        // log scale with a non-positive low bound
        set_regs(-65536, 655360, 1'b1);
        send_sample(32'h0001_0000);
        send_sample(32'h8000_0000);
        drain();

        // log scale where both bounds share one log value
        set_regs(64'h4000_0000, 64'h4000_0001, 1'b1);
        send_sample(32'h4000_0001);
        send_sample(32'h0000_0000);
        drain();

        // raised low bound lands above the high bound
        set_regs(100000, 100005, 1'b1);
        send_sample(32'd100000);
        send_sample(32'd100005);
        send_sample(32'd100002);
        drain();

        // widest linear range
        set_regs(S_MIN, S_MAX, 1'b0);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_0000);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin lo = -6553600;  hi = 3276800;     lg = 1'b0; end
                1: begin lo = S_MIN;     hi = S_MAX;       lg = 1'b0; end
                2: begin lo = 1;         hi = S_MAX;       lg = 1'b1; end
                3: begin lo = 65536;     hi = 268435456;   lg = 1'b1; end
                4: begin lo = 3000;      hi = 3017;        lg = 1'b0; end
                5: begin lo = S_MAX;     hi = S_MIN;       lg = 1'b1; end
                default: begin
                    lg = $urandom_range(0, 1);
                    if (lg && $urandom_range(0, 3) != 0) begin
                        lo = longint'($urandom_range(1, 32'h3FFF_FFFF));
                        hi = lo + longint'($urandom_range(0, 32'h3FFF_FFFF));
                    end else begin
                        lo = longint'($signed($urandom));
                        hi = longint'($signed($urandom));
                        if ($urandom_range(0, 3) != 0 && hi < lo) begin
                            hi = hi ^ lo;
                            lo = hi ^ lo;
                            hi = hi ^ lo;
                        end
                    end
                end
            endcase
            calm = (ph >= RAND_PHASES - 2);
            set_regs(lo, hi, lg);
            if (ph == 3)
                hold_long = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(pick_sample(lo, hi));
            drain();
        end

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && due_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: jet_pseudocolor_map.f
rtl/core/jpm_pkg.sv
rtl/core/jpm_log2.sv
rtl/core/jpm_div.sv
rtl/core/jpm_jet.sv
rtl/core/jet_pseudocolor_map.sv
tb/jpm_checker.sv
tb/tb_top.sv
